// ===== rtl/lcw_pkg.sv =====
// Shared types and codes for the LCW decompressor.
// Used by lcw_ctrl, lcw_hist and lcw_decompressor_core; no dependencies.
`default_nettype none

package lcw_pkg;

  localparam int HISTORY_DEPTH_DEF = 65536;

  // request codes
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // command bytes
  localparam logic [7:0] CMD_END  = 8'h80;
  localparam logic [7:0] CMD_FILL = 8'hfe;
  localparam logic [7:0] CMD_LONG = 8'hff;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_IN_RUN  = 3'd1;
  localparam logic [2:0] ERR_BAD_REF = 3'd2;
  localparam logic [2:0] ERR_FULL    = 3'd3;
  localparam logic [2:0] ERR_AFTER   = 3'd4;

  typedef enum logic [3:0] {
    PH_CMD    = 4'd0,
    PH_REL    = 4'd1,
    PH_LIT    = 4'd2,
    PH_MED0   = 4'd3,
    PH_MED1   = 4'd4,
    PH_FILLC0 = 4'd5,
    PH_FILLC1 = 4'd6,
    PH_FILLV  = 4'd7,
    PH_LONGC0 = 4'd8,
    PH_LONGC1 = 4'd9,
    PH_LONGP0 = 4'd10,
    PH_LONGP1 = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_COPY = 2'd1,
    KIND_FILL = 2'd2
  } kind_t;

  // one request as issued by the control stage to the history stage
  typedef struct packed {
    logic        wr;        // a byte is produced and stored
    logic        copy;      // byte comes from the store
    logic        range_ok;  // read position holds a written byte
    logic [15:0] raddr;
    logic [15:0] waddr;
    logic [7:0]  lit;       // literal or fill byte
    logic        need;
    logic        done;
    logic [16:0] count;
    logic [2:0]  err;
  } issue_t;

endpackage

`default_nettype wire

// ===== rtl/lcw_decompressor_core.sv =====
// LCW (format80) decompressor top level: control stage and history pipeline.
// Instantiates lcw_ctrl and lcw_hist; uses lcw_pkg.
//
// Input requests (in_op, in_byte) are taken on in_valid && !in_stall. Op 0 feeds a
// compressed byte to the command parser, op 1 (tick) moves a pending copy or fill
// on by one byte, op 2 restarts the section. Every accepted request gives exactly
// one result on the out_ channel, taken on out_valid && !out_stall, carrying the
// produced byte (if any) and status after that request.
// An accepted request passes the p1 register and then the output register, where
// out_valid rises. Throughput: one request per cycle sustained while out_stall is
// low; each produced byte is a read of the history RAM in the accept cycle and a
// write when the request leaves p1, with a bypass for a copy at distance one.
// When out_stall is held, the output register and one request in flight fill,
// then in_stall rises in the same cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears parser, counts and the pipeline; the
// history RAM is not cleared, since only written entries are ever referenced.
`default_nettype none

module lcw_decompressor_core
  import lcw_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_out_valid,
  output logic [7:0]       out_byte,
  output logic             out_need_byte,
  output logic             out_done_res,
  output logic [16:0]      out_written_count,
  output logic [2:0]       out_error
);

  logic   acc;
  issue_t req;

  assign acc = in_valid && !in_stall;

  lcw_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_op   (in_op),
    .in_byte (in_byte),
    .req     (req)
  );

  lcw_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk               (clk),
    .rst_n             (rst_n),
    .acc               (acc),
    .req               (req),
    .stall_up          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_valid     (out_out_valid),
    .out_byte          (out_byte),
    .out_need_byte     (out_need_byte),
    .out_done_res      (out_done_res),
    .out_written_count (out_written_count),
    .out_error         (out_error)
  );

endmodule

`default_nettype wire

// ===== rtl/lcw_ctrl.sv =====
// Command parser and run sequencer of the LCW decompressor.
// Holds all scalar state and issues one request per accepted item; uses lcw_pkg.
`default_nettype none

module lcw_ctrl
  import lcw_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_byte,
  output issue_t          req
);

  localparam logic [16:0] DEPTH_C = 17'(HISTORY_DEPTH);

  logic [16:0] wpos_r, wpos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [23:0] hdr_r, hdr_nxt;
  logic [15:0] left_r, left_nxt;
  kind_t       kind_r, kind_nxt;
  logic [15:0] rpos_r, rpos_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic        fin_r, fin_nxt;

  always_comb begin
    logic        sc_go;
    logic [15:0] sc_cnt;
    logic [15:0] sc_src;
    logic [11:0] rel_dist;

    wpos_nxt  = wpos_r;
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    left_nxt  = left_r;
    kind_nxt  = kind_r;
    rpos_nxt  = rpos_r;
    fill_nxt  = fill_r;
    fin_nxt   = fin_r;
    sc_go     = 1'b0;
    sc_cnt    = 16'h0;
    sc_src    = 16'h0;
    rel_dist  = {hdr_r[3:0], in_byte};

    req          = '0;
    req.raddr    = rpos_r;
    req.waddr    = wpos_r[15:0];
    req.lit      = in_byte;
    req.range_ok = ({1'b0, rpos_r} < wpos_r) && ({1'b0, rpos_r} < DEPTH_C);
    req.err      = ERR_NONE;

    case (in_op)
      OP_RESTART: begin
        wpos_nxt  = '0;
        phase_nxt = PH_CMD;
        hdr_nxt   = '0;
        left_nxt  = '0;
        kind_nxt  = KIND_NONE;
        rpos_nxt  = '0;
        fill_nxt  = '0;
        fin_nxt   = 1'b0;
      end
      OP_TICK: begin
        if (kind_r != KIND_NONE) begin
          if (wpos_r >= DEPTH_C) begin
            req.err  = ERR_FULL;
            kind_nxt = KIND_NONE;
            left_nxt = '0;
          end else begin
            req.wr   = 1'b1;
            req.copy = (kind_r == KIND_COPY);
            req.lit  = fill_r;
            wpos_nxt = wpos_r + 17'd1;
            rpos_nxt = rpos_r + 16'd1;
            left_nxt = left_r - 16'd1;
            if (left_r == 16'd1) kind_nxt = KIND_NONE;
          end
        end
      end
      OP_BYTE: begin
        if (fin_r) begin
          req.err = ERR_AFTER;
        end else if (kind_r != KIND_NONE) begin
          req.err = ERR_IN_RUN;
        end else begin
          case (phase_r)
            PH_CMD: begin
              hdr_nxt = {16'h0, in_byte};
              if (!in_byte[7]) begin
                phase_nxt = PH_REL;
              end else if (in_byte == CMD_END) begin
                fin_nxt = 1'b1;
              end else if (!in_byte[6]) begin
                left_nxt  = {10'h0, in_byte[5:0]};
                phase_nxt = PH_LIT;
              end else if (in_byte == CMD_FILL) begin
                phase_nxt = PH_FILLC0;
              end else if (in_byte == CMD_LONG) begin
                phase_nxt = PH_LONGC0;
              end else begin
                hdr_nxt   = {16'h0, 8'({2'b00, in_byte[5:0]} + 8'd3)};
                phase_nxt = PH_MED0;
              end
            end
            PH_REL: begin
              phase_nxt = PH_CMD;
              if (rel_dist == 12'h0 || {5'h0, rel_dist} > wpos_r) begin
                req.err = ERR_BAD_REF;
              end else begin
                kind_nxt = KIND_COPY;
                left_nxt = {12'h0, {1'b0, hdr_r[6:4]} + 4'd3};
                rpos_nxt = wpos_r[15:0] - {4'h0, rel_dist};
              end
            end
            PH_LIT: begin
              if (wpos_r < DEPTH_C) begin
                req.wr   = 1'b1;
                wpos_nxt = wpos_r + 17'd1;
              end else begin
                req.err = ERR_FULL;
              end
              left_nxt = left_r - 16'd1;
              if (left_r == 16'd1) phase_nxt = PH_CMD;
            end
            PH_MED0: begin
              hdr_nxt   = {8'h0, in_byte, hdr_r[7:0]};
              phase_nxt = PH_MED1;
            end
            PH_MED1: begin
              phase_nxt = PH_CMD;
              sc_go     = 1'b1;
              sc_cnt    = {8'h0, hdr_r[7:0]};
              sc_src    = {in_byte, hdr_r[15:8]};
            end
            PH_FILLC0: begin
              hdr_nxt   = {16'h0, in_byte};
              phase_nxt = PH_FILLC1;
            end
            PH_FILLC1: begin
              hdr_nxt   = {8'h0, in_byte, hdr_r[7:0]};
              phase_nxt = PH_FILLV;
            end
            PH_FILLV: begin
              phase_nxt = PH_CMD;
              fill_nxt  = in_byte;
              if (hdr_r[15:0] != 16'h0) begin
                kind_nxt = KIND_FILL;
                left_nxt = hdr_r[15:0];
              end
            end
            PH_LONGC0: begin
              hdr_nxt   = {16'h0, in_byte};
              phase_nxt = PH_LONGC1;
            end
            PH_LONGC1: begin
              hdr_nxt   = {8'h0, in_byte, hdr_r[7:0]};
              phase_nxt = PH_LONGP0;
            end
            PH_LONGP0: begin
              hdr_nxt   = {in_byte, hdr_r[15:0]};
              phase_nxt = PH_LONGP1;
            end
            PH_LONGP1: begin
              phase_nxt = PH_CMD;
              sc_go     = 1'b1;
              sc_cnt    = hdr_r[15:0];
              sc_src    = {in_byte, hdr_r[23:16]};
            end
            default: begin
              phase_nxt = PH_CMD;
            end
          endcase

          // absolute copy start: empty copies vanish, source must be written
          if (sc_go && sc_cnt != 16'h0) begin
            if ({1'b0, sc_src} >= wpos_r) begin
              req.err = ERR_BAD_REF;
            end else begin
              kind_nxt = KIND_COPY;
              left_nxt = sc_cnt;
              rpos_nxt = sc_src;
            end
          end
        end
      end
      default: begin
      end
    endcase

    req.need  = (kind_nxt == KIND_NONE) && !fin_nxt;
    req.done  = fin_nxt;
    req.count = wpos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r  <= '0;
      phase_r <= PH_CMD;
      hdr_r   <= '0;
      left_r  <= '0;
      kind_r  <= KIND_NONE;
      rpos_r  <= '0;
      fill_r  <= '0;
      fin_r   <= 1'b0;
    end else if (acc) begin
      wpos_r  <= wpos_nxt;
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      left_r  <= left_nxt;
      kind_r  <= kind_nxt;
      rpos_r  <= rpos_nxt;
      fill_r  <= fill_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcw_hist.sv =====
// History store, read/write pipeline and output register of the LCW decompressor.
// Takes requests from lcw_ctrl; uses lcw_pkg.
`default_nettype none

module lcw_hist
  import lcw_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire issue_t      req,
  output logic             stall_up,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_out_valid,
  output logic [7:0]       out_byte,
  output logic             out_need_byte,
  output logic             out_done_res,
  output logic [16:0]      out_written_count,
  output logic [2:0]       out_error
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic [7:0] mem [HISTORY_DEPTH];

  logic       p1_valid_r, p1_valid_nxt;
  issue_t     p1_r;
  logic [7:0] rdata_r;
  logic       fwd_r;
  logic [7:0] fwd_data_r;
  logic       ov_r, ov_nxt;
  logic       adv;
  logic [7:0] wbyte;

  assign adv      = p1_valid_r && (!ov_r || !out_stall);
  assign stall_up = p1_valid_r && !adv;

  // a read issued in the same cycle as a write to that entry sees old data
  always_comb begin
    if (!p1_r.copy)         wbyte = p1_r.lit;
    else if (!p1_r.range_ok) wbyte = 8'h00;
    else if (fwd_r)         wbyte = fwd_data_r;
    else                    wbyte = rdata_r;
  end

  always_comb begin
    p1_valid_nxt = p1_valid_r;
    if (acc)      p1_valid_nxt = 1'b1;
    else if (adv) p1_valid_nxt = 1'b0;
    ov_nxt = ov_r && out_stall;
    if (adv) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p1_r.wr) begin
      mem[p1_r.waddr[AW-1:0]] <= wbyte;
    end
    if (acc) begin
      rdata_r    <= mem[req.raddr[AW-1:0]];
      fwd_r      <= adv && p1_r.wr && (p1_r.waddr[AW-1:0] == req.raddr[AW-1:0]);
      fwd_data_r <= wbyte;
      p1_r       <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_out_valid     <= p1_r.wr;
      out_byte          <= p1_r.wr ? wbyte : 8'h00;
      out_need_byte     <= p1_r.need;
      out_done_res      <= p1_r.done;
      out_written_count <= p1_r.count;
      out_error         <= p1_r.err;
    end
  end

  assign out_valid = ov_r;

endmodule

`default_nettype wire
